FILE: design/tccg_pkg.sv
`default_nettype none

package tccg_pkg;

   // grid geometry
   localparam int MAX_ROWS  = 32;
   localparam int MAX_COLS  = 128;
   localparam int ROW_AW    = $clog2(MAX_ROWS);
   localparam int COL_AW    = $clog2(MAX_COLS);
   localparam int ADDR_W    = ROW_AW + COL_AW;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   // widths of counts that can reach the maximum itself
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int COLS_W = $clog2(MAX_COLS + 1);

   // fixed field widths
   localparam int CHAR_W     = 8;
   localparam int READ_ROW_W = 5;
   localparam int READ_COL_W = 7;
   localparam int ROWS_CFG_W = 6;
   localparam int COLS_CFG_W = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(24);
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(80);

   // control characters
   localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
   localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_FF = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_SP = 8'h20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_idx_type;

   typedef enum logic [0:0] {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_COPY,
      ST_FILL,
      ST_PUT,
      ST_READ,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

FILE: design/text_console_char_grid.sv
`default_nettype none

// channel   ports                                          direction
// -------   --------------------------------------------   ---------
// req       req_valid/req_ready, op, char_in, read_row/col in
// rsp       rsp_valid/rsp_ready, cell_char, cursor, flags  out
// csr       csr_wr_en, csr_index, csr_wr_data              in
//
// read or put: after accept, a ram step (ST_READ or ST_PUT), a result load (ST_RESP), then idle;
// an outside read, an on-screen newline or a backspace that blanks nothing skip the ram step
// a scroll adds a copy pass (ST_COPY) moving rows up and a fill pass (ST_FILL), just the fill on a one-row grid
// form feed adds a clearing pass over all MAX_ROWS*MAX_COLS cells (4096), one cell cleared per cycle
// after reset the same clearing pass over the whole store runs before req_ready rises
// req_ready is high only while idle; a result waiting on rsp does not block accept

module text_console_char_grid (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_op,
   input  wire logic [tccg_pkg::CHAR_W-1:0]      req_char_in,
   input  wire logic [tccg_pkg::READ_ROW_W-1:0]  req_read_row,
   input  wire logic [tccg_pkg::READ_COL_W-1:0]  req_read_col,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [tccg_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic      [tccg_pkg::COLS_W-1:0]      rsp_cursor_col,
   output logic      [tccg_pkg::ROWS_W-1:0]      rsp_cursor_row,
   output logic                                  rsp_scrolled,
   output logic                                  rsp_cleared,

   input  wire logic                             csr_wr_en,
   input  wire logic [tccg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tccg_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   // sequencer state
   tccg_pkg::state_type state_ff, state_in;

   // configuration
   logic [tccg_pkg::ROWS_CFG_W-1:0] rows_cfg_ff;
   logic [tccg_pkg::COLS_CFG_W-1:0] cols_cfg_ff;
   logic [tccg_pkg::ROWS_W-1:0]     rows_eff, rows_last;
   logic [tccg_pkg::COLS_W-1:0]     cols_eff, cols_last;

   // cursor
   logic [tccg_pkg::ROWS_W-1:0] cur_row_ff, cur_row_in;
   logic [tccg_pkg::COLS_W-1:0] cur_col_ff, cur_col_in;

   // walk counters shared by scroll copy and fill
   logic [tccg_pkg::ROW_AW-1:0] walk_row_ff, walk_row_in;
   logic [tccg_pkg::COL_AW-1:0] walk_col_ff, walk_col_in;
   logic [tccg_pkg::ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // copy write happens in the cycle after its read
   logic                        pend_ff, pend_in;
   logic [tccg_pkg::ADDR_W-1:0] pend_addr_ff, pend_addr_in;

   // pending cell write and item bookkeeping
   logic [tccg_pkg::CHAR_W-1:0] put_data_ff, put_data_in;
   logic                        put_en_ff, put_en_in;
   logic                        put_adv_ff, put_adv_in;
   logic                        after_put_ff, after_put_in;
   logic [tccg_pkg::CHAR_W-1:0] cell_ff, cell_in;
   logic                        scr_ff, scr_in;
   logic                        clr_ff, clr_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tccg_pkg::CHAR_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [tccg_pkg::COLS_W-1:0] rsp_col_ff, rsp_col_in;
   logic [tccg_pkg::ROWS_W-1:0] rsp_row_ff, rsp_row_in;
   logic                        rsp_scr_ff, rsp_scr_in;
   logic                        rsp_clr_ff, rsp_clr_in;

   // grid ram port
   logic                        mem_wr_en;
   logic [tccg_pkg::ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [tccg_pkg::CHAR_W-1:0] mem_wr_data, mem_rd_data;

   // decode of the offered item
   logic                        accept;
   logic                        row_below, col_below;
   logic                        need_scroll_put;
   logic                        read_inside;
   logic [tccg_pkg::COLS_W-1:0] bs_col;
   logic                        bs_write;
   logic                        walk_col_last, walk_row_last;
   logic                        clr_last, out_free;
   tccg_pkg::state_type         scroll_state;

   // zero counts as one, oversize counts as the maximum
   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = tccg_pkg::ROWS_W'(1);
      end else if (tccg_pkg::ROWS_W'(rows_cfg_ff) > tccg_pkg::ROWS_W'(tccg_pkg::MAX_ROWS)) begin
         rows_eff = tccg_pkg::ROWS_W'(tccg_pkg::MAX_ROWS);
      end else begin
         rows_eff = tccg_pkg::ROWS_W'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = tccg_pkg::COLS_W'(1);
      end else if (tccg_pkg::COLS_W'(cols_cfg_ff) > tccg_pkg::COLS_W'(tccg_pkg::MAX_COLS)) begin
         cols_eff = tccg_pkg::COLS_W'(tccg_pkg::MAX_COLS);
      end else begin
         cols_eff = tccg_pkg::COLS_W'(cols_cfg_ff);
      end
   end

   assign rows_last = rows_eff - tccg_pkg::ROWS_W'(1);
   assign cols_last = cols_eff - tccg_pkg::COLS_W'(1);

   assign req_ready = (state_ff == tccg_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign row_below       = cur_row_ff < rows_eff;
   assign col_below       = cur_col_ff < cols_eff;
   // past the bottom, or on a full last row
   assign need_scroll_put = !row_below || ((cur_row_ff == rows_last) && !col_below);
   assign read_inside     = (tccg_pkg::ROWS_W'(req_read_row) < rows_eff)
                         && (tccg_pkg::COLS_W'(req_read_col) < cols_eff);
   assign bs_col          = cur_col_ff - tccg_pkg::COLS_W'(1);
   // backspace blanks only inside the region in use
   assign bs_write        = (cur_col_ff != '0) && row_below && (bs_col < cols_eff);

   assign walk_col_last = tccg_pkg::COLS_W'(walk_col_ff) == cols_last;
   assign walk_row_last = tccg_pkg::ROWS_W'(walk_row_ff) == rows_last;
   assign clr_last      = clr_addr_ff == '1;
   // single row grid has nothing to move up
   assign scroll_state  = (rows_eff == tccg_pkg::ROWS_W'(1)) ? tccg_pkg::ST_FILL
                                                             : tccg_pkg::ST_COPY;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tccg_pkg::ST_INIT: begin
            if (clr_last) begin
               state_in = tccg_pkg::ST_IDLE;
            end
         end
         tccg_pkg::ST_IDLE: begin
            if (accept) begin
               if (tccg_pkg::op_type'(req_op) == tccg_pkg::OP_READ) begin
                  state_in = read_inside ? tccg_pkg::ST_READ : tccg_pkg::ST_RESP;
               end else begin
                  unique case (req_char_in)
                     tccg_pkg::CH_BS: state_in = bs_write ? tccg_pkg::ST_PUT
                                                          : tccg_pkg::ST_RESP;
                     tccg_pkg::CH_NL: state_in = row_below ? tccg_pkg::ST_RESP
                                                           : scroll_state;
                     tccg_pkg::CH_FF: state_in = tccg_pkg::ST_CLEAR;
                     default:         state_in = need_scroll_put ? scroll_state
                                                                 : tccg_pkg::ST_PUT;
                  endcase
               end
            end
         end
         tccg_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = tccg_pkg::ST_RESP;
            end
         end
         tccg_pkg::ST_COPY: begin
            if (walk_col_last && walk_row_last) begin
               state_in = tccg_pkg::ST_FILL;
            end
         end
         tccg_pkg::ST_FILL: begin
            if (!pend_ff && walk_col_last) begin
               state_in = after_put_ff ? tccg_pkg::ST_PUT : tccg_pkg::ST_RESP;
            end
         end
         tccg_pkg::ST_PUT:  state_in = tccg_pkg::ST_RESP;
         tccg_pkg::ST_READ: state_in = tccg_pkg::ST_RESP;
         tccg_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = tccg_pkg::ST_IDLE;
            end
         end
         default: state_in = tccg_pkg::ST_IDLE;
      endcase
   end

   // datapath, ram control and result register
   always_comb begin
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      walk_row_in  = walk_row_ff;
      walk_col_in  = walk_col_ff;
      clr_addr_in  = clr_addr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      put_data_in  = put_data_ff;
      put_en_in    = put_en_ff;
      put_adv_in   = put_adv_ff;
      after_put_in = after_put_ff;
      cell_in      = cell_ff;
      scr_in       = scr_ff;
      clr_in       = clr_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cell_in  = rsp_cell_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_scr_in   = rsp_scr_ff;
      rsp_clr_in   = rsp_clr_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_addr_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_addr = {walk_row_ff, walk_col_ff};

      unique case (state_ff)
         tccg_pkg::ST_INIT, tccg_pkg::ST_CLEAR: begin
            // one cell of the whole store per cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = tccg_pkg::CH_SP;
            clr_addr_in = clr_addr_ff + tccg_pkg::ADDR_W'(1);
         end
         tccg_pkg::ST_IDLE: begin
            // read issued at accept, data lands in ST_READ
            mem_rd_addr = {tccg_pkg::ROW_AW'(req_read_row), tccg_pkg::COL_AW'(req_read_col)};
            clr_addr_in = '0;
            if (accept) begin
               scr_in       = 1'b0;
               clr_in       = 1'b0;
               cell_in      = '0;
               put_en_in    = 1'b1;
               put_adv_in   = 1'b1;
               put_data_in  = req_char_in;
               after_put_in = 1'b1;
               walk_row_in  = tccg_pkg::ROW_AW'(1);
               walk_col_in  = '0;
               if (tccg_pkg::op_type'(req_op) == tccg_pkg::OP_READ) begin
                  cell_in = tccg_pkg::CH_SP;
               end else begin
                  unique case (req_char_in)
                     tccg_pkg::CH_BS: begin
                        put_data_in = tccg_pkg::CH_SP;
                        put_adv_in  = 1'b0;
                        if (cur_col_ff != '0) begin
                           cur_col_in = bs_col;
                        end
                     end
                     tccg_pkg::CH_NL: begin
                        after_put_in = 1'b0;
                        if (row_below) begin
                           cur_col_in = '0;
                           cur_row_in = cur_row_ff + tccg_pkg::ROWS_W'(1);
                        end else begin
                           scr_in = 1'b1;
                        end
                     end
                     tccg_pkg::CH_FF: begin
                        cur_col_in = '0;
                        cur_row_in = '0;
                        clr_in     = 1'b1;
                     end
                     default: begin
                        if (need_scroll_put) begin
                           scr_in = 1'b1;
                        end else if (!col_below) begin
                           // row full: wrap to the next row
                           cur_col_in = '0;
                           cur_row_in = cur_row_ff + tccg_pkg::ROWS_W'(1);
                        end
                     end
                  endcase
               end
            end
         end
         tccg_pkg::ST_COPY: begin
            // read row r+1 now, write it into row r next cycle
            pend_in      = 1'b1;
            pend_addr_in = {walk_row_ff - tccg_pkg::ROW_AW'(1), walk_col_ff};
            mem_wr_en    = pend_ff;
            if (walk_col_last) begin
               walk_col_in = '0;
               if (!walk_row_last) begin
                  walk_row_in = walk_row_ff + tccg_pkg::ROW_AW'(1);
               end
            end else begin
               walk_col_in = walk_col_ff + tccg_pkg::COL_AW'(1);
            end
         end
         tccg_pkg::ST_FILL: begin
            if (pend_ff) begin
               // last copy write drains first
               mem_wr_en = 1'b1;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = {tccg_pkg::ROW_AW'(rows_last), walk_col_ff};
               mem_wr_data = tccg_pkg::CH_SP;
               walk_col_in = walk_col_ff + tccg_pkg::COL_AW'(1);
               if (walk_col_last) begin
                  cur_row_in = rows_last;
                  cur_col_in = '0;
               end
            end
         end
         tccg_pkg::ST_PUT: begin
            mem_wr_en   = put_en_ff;
            mem_wr_addr = {tccg_pkg::ROW_AW'(cur_row_ff), tccg_pkg::COL_AW'(cur_col_ff)};
            mem_wr_data = put_data_ff;
            if (put_adv_ff) begin
               cur_col_in = cur_col_ff + tccg_pkg::COLS_W'(1);
            end
         end
         tccg_pkg::ST_READ: begin
            cell_in = mem_rd_data;
         end
         tccg_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_ff;
               rsp_col_in   = cur_col_ff;
               rsp_row_in   = cur_row_ff;
               rsp_scr_in   = scr_ff;
               rsp_clr_in   = clr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccg_pkg::ST_INIT;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         rows_cfg_ff  <= tccg_pkg::ROWS_RESET;
         cols_cfg_ff  <= tccg_pkg::COLS_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         if (csr_wr_en) begin
            unique case (tccg_pkg::csr_idx_type'(csr_index))
               tccg_pkg::CSR_ROWS: rows_cfg_ff <= csr_wr_data[tccg_pkg::ROWS_CFG_W-1:0];
               tccg_pkg::CSR_COLS: cols_cfg_ff <= csr_wr_data[tccg_pkg::COLS_CFG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      walk_row_ff  <= walk_row_in;
      walk_col_ff  <= walk_col_in;
      pend_addr_ff <= pend_addr_in;
      put_data_ff  <= put_data_in;
      put_en_ff    <= put_en_in;
      put_adv_ff   <= put_adv_in;
      after_put_ff <= after_put_in;
      cell_ff      <= cell_in;
      scr_ff       <= scr_in;
      clr_ff       <= clr_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_scr_ff   <= rsp_scr_in;
      rsp_clr_ff   <= rsp_clr_in;
   end

   // character store, one write and one registered read per cycle
   tccg_ram #(
      .WIDTH (tccg_pkg::CHAR_W),
      .DEPTH (tccg_pkg::MEM_DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scr_ff;
   assign rsp_cleared    = rsp_clr_ff;

endmodule

`default_nettype wire

FILE: design/tccg_ram.sv
`default_nettype none

module tccg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
